FILE: rtl/ebga_pkg.sv
// ----------------------------------------------------------------------------
// ebga_pkg
// Shared constants, job codes and control structs of the eye blink and gaze
// animator.
// ----------------------------------------------------------------------------
package ebga_pkg;

  localparam int CFG_NUM   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int WAIT_W    = 17;
  localparam int JOB_W     = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_SPAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SPAN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_BASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_SPAN = 3'd6;

  localparam logic [15:0] RST_BLINK_LEN   = 16'd150;
  localparam logic [15:0] RST_BLINK_BASE  = 16'd3000;
  localparam logic [15:0] RST_BLINK_SPAN  = 16'd4000;
  localparam logic [15:0] RST_WIDE_BASE   = 16'd2000;
  localparam logic [15:0] RST_WIDE_SPAN   = 16'd4000;
  localparam logic [15:0] RST_NARROW_BASE = 16'd300;
  localparam logic [15:0] RST_NARROW_SPAN = 16'd500;

  localparam logic [15:0] WIDE_RANGE   = 16'd1800;
  localparam logic [15:0] NARROW_RANGE = 16'd200;
  localparam logic [15:0] TGT_DIV      = 16'd1000;
  localparam logic [15:0] SMOOTH_DIV   = 16'd10;

  // (rem - range/2) * 16384 + 500, shifted up by 16384 * 1000 to stay positive
  localparam logic [31:0] WIDE_TGT_OFS   = 32'd1638900;
  localparam logic [31:0] NARROW_TGT_OFS = 32'd14746100;
  localparam logic [15:0] TGT_BIAS       = 16'd16384;
  // d + 5, shifted up by 10 * 10000
  localparam logic [31:0] SMOOTH_OFS     = 32'd100005;
  localparam logic [15:0] SMOOTH_BIAS    = 16'd10000;

  // job sequence of one tick
  localparam logic [JOB_W-1:0] JOB_BLINK_CHK   = 5'd0;
  localparam logic [JOB_W-1:0] JOB_BLINK_WAIT  = 5'd1;
  localparam logic [JOB_W-1:0] JOB_BLINK_F     = 5'd2;
  localparam logic [JOB_W-1:0] JOB_MUL_L       = 5'd3;
  localparam logic [JOB_W-1:0] JOB_MUL_R       = 5'd4;
  localparam logic [JOB_W-1:0] JOB_WIDE_CHK    = 5'd5;
  localparam logic [JOB_W-1:0] JOB_WIDE_WAIT   = 5'd6;
  localparam logic [JOB_W-1:0] JOB_WIDE_X_MOD  = 5'd7;
  localparam logic [JOB_W-1:0] JOB_WIDE_X_TGT  = 5'd8;
  localparam logic [JOB_W-1:0] JOB_WIDE_Y_MOD  = 5'd9;
  localparam logic [JOB_W-1:0] JOB_WIDE_Y_TGT  = 5'd10;
  localparam logic [JOB_W-1:0] JOB_NAR_CHK     = 5'd11;
  localparam logic [JOB_W-1:0] JOB_NAR_WAIT    = 5'd12;
  localparam logic [JOB_W-1:0] JOB_NAR_X_MOD   = 5'd13;
  localparam logic [JOB_W-1:0] JOB_NAR_X_TGT   = 5'd14;
  localparam logic [JOB_W-1:0] JOB_NAR_Y_MOD   = 5'd15;
  localparam logic [JOB_W-1:0] JOB_NAR_Y_TGT   = 5'd16;
  localparam logic [JOB_W-1:0] JOB_SMOOTH_X    = 5'd17;
  localparam logic [JOB_W-1:0] JOB_SMOOTH_Y    = 5'd18;
  localparam logic [JOB_W-1:0] JOB_LAST        = JOB_SMOOTH_Y;

  typedef struct packed {
    logic             latch;
    logic             start;
    logic             apply;
    logic             load_out;
    logic [JOB_W-1:0] job;
  } ebga_cmd_t;

  typedef struct packed {
    logic need;
    logic div_done;
    logic div_busy;
  } ebga_stat_t;

endpackage

FILE: rtl/ebga_ifs.sv
// ----------------------------------------------------------------------------
// ebga channel interfaces
// Valid/ready channels for tick words, result words and register writes.
// ----------------------------------------------------------------------------
interface ebga_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic [15:0]        open_left_in;
  logic [15:0]        open_right_in;
  logic signed [15:0] gaze_x_in;
  logic signed [15:0] gaze_y_in;
  logic [31:0]        rand_blink_gap;
  logic [31:0]        rand_wide_gap;
  logic [31:0]        rand_wide_x;
  logic [31:0]        rand_wide_y;
  logic [31:0]        rand_narrow_gap;
  logic [31:0]        rand_narrow_x;
  logic [31:0]        rand_narrow_y;

  modport source (
    output valid, now_ms, open_left_in, open_right_in, gaze_x_in, gaze_y_in,
           rand_blink_gap, rand_wide_gap, rand_wide_x, rand_wide_y,
           rand_narrow_gap, rand_narrow_x, rand_narrow_y,
    input  ready
  );
  modport sink (
    input  valid, now_ms, open_left_in, open_right_in, gaze_x_in, gaze_y_in,
           rand_blink_gap, rand_wide_gap, rand_wide_x, rand_wide_y,
           rand_narrow_gap, rand_narrow_x, rand_narrow_y,
    output ready
  );
endinterface

interface ebga_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        open_left_out;
  logic [15:0]        open_right_out;
  logic signed [15:0] gaze_x_out;
  logic signed [15:0] gaze_y_out;

  modport source (
    output valid, open_left_out, open_right_out, gaze_x_out, gaze_y_out,
    input  ready
  );
  modport sink (
    input  valid, open_left_out, open_right_out, gaze_x_out, gaze_y_out,
    output ready
  );
endinterface

interface ebga_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: rtl/ebga_div.sv
// ----------------------------------------------------------------------------
// ebga_div
// Restoring divider, 32-bit dividend by 16-bit divisor, four quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module ebga_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot,
  output logic [15:0] rem
);

  logic [31:0] q;
  logic [15:0] r;
  logic [15:0] d;
  logic [2:0]  cnt;
  logic [31:0] q_next;
  logic [15:0] r_next;

  always_comb begin
    logic [16:0] t;
    q_next = q;
    r_next = r;
    for (int k = 0; k < 4; k++) begin
      t = {r_next, q_next[31]};
      if (t >= {1'b0, d}) begin
        r_next = 16'(t - {1'b0, d});
        q_next = {q_next[30:0], 1'b1};
      end else begin
        r_next = t[15:0];
        q_next = {q_next[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

FILE: rtl/ebga_ctrl.sv
// ----------------------------------------------------------------------------
// ebga_ctrl
// Tick sequencer: walks the job list, starts divisions, hands off results.
// ----------------------------------------------------------------------------
module ebga_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ebga_pkg::ebga_stat_t stat,
  output ebga_pkg::ebga_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                 state;
  logic [ebga_pkg::JOB_W-1:0] job;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.job      = job;
    cmd.latch    = in_valid && in_ready;
    case (state)
      S_EVAL: begin
        cmd.start = stat.need;
        cmd.apply = !stat.need;
      end
      S_DIV: begin
        cmd.apply = stat.div_done;
      end
      S_OUT: begin
        cmd.load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.latch) begin
            job   <= ebga_pkg::JOB_BLINK_CHK;
            state <= S_EVAL;
          end
        end
        S_EVAL, S_DIV: begin
          if (cmd.start) begin
            state <= S_DIV;
          end else if (cmd.apply) begin
            if (job == ebga_pkg::JOB_LAST) begin
              state <= S_OUT;
            end else begin
              job   <= job + 5'd1;
              state <= S_EVAL;
            end
          end
        end
        S_OUT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/ebga_dp.sv
// ----------------------------------------------------------------------------
// ebga_dp
// Datapath: registers, timers, gaze targets and offsets, blink scaling and
// the shared divider.
// ----------------------------------------------------------------------------
module ebga_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  ebga_pkg::ebga_cmd_t             cmd,
  output ebga_pkg::ebga_stat_t            stat,
  input  logic                            cfg_we,
  input  logic [ebga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic [31:0]                     now_ms,
  input  logic [15:0]                     open_left_in,
  input  logic [15:0]                     open_right_in,
  input  logic signed [15:0]              gaze_x_in,
  input  logic signed [15:0]              gaze_y_in,
  input  logic [31:0]                     rand_blink_gap,
  input  logic [31:0]                     rand_wide_gap,
  input  logic [31:0]                     rand_wide_x,
  input  logic [31:0]                     rand_wide_y,
  input  logic [31:0]                     rand_narrow_gap,
  input  logic [31:0]                     rand_narrow_x,
  input  logic [31:0]                     rand_narrow_y,
  output logic [15:0]                     open_left_out,
  output logic [15:0]                     open_right_out,
  output logic signed [15:0]              gaze_x_out,
  output logic signed [15:0]              gaze_y_out
);

  localparam int WW = ebga_pkg::WAIT_W;

  logic [15:0] cfg_reg [ebga_pkg::CFG_NUM];

  // latched tick word
  logic [31:0]        now;
  logic [15:0]        ol, orr;
  logic signed [15:0] gx, gy;
  logic [31:0]        r_bg, r_wg, r_wx, r_wy, r_ng, r_nx, r_ny;

  // timer and gaze state
  logic [31:0]        bstart, wtime, ntime;
  logic [WW-1:0]      bwait, wwait, nwait;
  logic               blinking, bfire, wfire, nfire, scale;
  logic [15:0]        f, tmp;
  logic signed [15:0] wtgt [2];
  logic signed [15:0] ntgt [2];
  logic signed [15:0] wsm [2];
  logic signed [15:0] nsm [2];

  // divider
  logic        div_busy, div_done;
  logic [31:0] div_dividend, quot;
  logic [15:0] div_divisor, rem;
  logic        need;

  logic [31:0] el_b, el_w, el_n;
  logic        e_lt_len;
  logic [16:0] twice, len17, dist17;
  logic        sel;
  logic signed [16:0] wd, nd, nd1;
  logic [15:0] mul_a;
  logic [31:0] prod;
  logic signed [17:0] sum_x, sum_y;

  function automatic logic [WW-1:0] wait_sum(input logic [15:0] base,
                                             input logic [15:0] span,
                                             input logic [15:0] r);
    logic [15:0] spread;
    spread   = (span == '0) ? '0 : r;
    wait_sum = {1'b0, base} + {1'b0, spread};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      sat16 = -16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  ebga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign el_b = now - bstart;
  assign el_w = now - wtime;
  assign el_n = now - ntime;

  // triangle factor operands, only used while e < length
  assign e_lt_len = el_b < {16'd0, cfg_reg[ebga_pkg::REG_BLINK_LEN]};
  assign twice    = {el_b[15:0], 1'b0};
  assign len17    = {1'b0, cfg_reg[ebga_pkg::REG_BLINK_LEN]};
  assign dist17   = (twice < len17) ? (len17 - twice) : (twice - len17);

  assign sel = (cmd.job == ebga_pkg::JOB_SMOOTH_Y);
  assign wd  = {wtgt[sel][15], wtgt[sel]} - {wsm[sel][15], wsm[sel]};
  assign nd  = {ntgt[sel][15], ntgt[sel]} - {nsm[sel][15], nsm[sel]};
  assign nd1 = nd + 17'sd1;

  assign mul_a = (cmd.job == ebga_pkg::JOB_MUL_R) ? orr : ol;
  assign prod  = mul_a * f;

  assign sum_x = 18'(gx) + 18'(wsm[0]) + 18'(nsm[0]);
  assign sum_y = 18'(gy) + 18'(wsm[1]) + 18'(nsm[1]);

  always_comb begin
    need         = 1'b0;
    div_dividend = '0;
    div_divisor  = ebga_pkg::SMOOTH_DIV;
    case (cmd.job)
      ebga_pkg::JOB_BLINK_WAIT: begin
        need         = bfire && (cfg_reg[ebga_pkg::REG_BLINK_SPAN] != '0);
        div_dividend = r_bg;
        div_divisor  = cfg_reg[ebga_pkg::REG_BLINK_SPAN];
      end
      ebga_pkg::JOB_BLINK_F: begin
        need         = blinking && e_lt_len;
        div_dividend = {1'b0, dist17[15:0], 15'd0};
        div_divisor  = cfg_reg[ebga_pkg::REG_BLINK_LEN];
      end
      ebga_pkg::JOB_WIDE_WAIT: begin
        need         = wfire && (cfg_reg[ebga_pkg::REG_WIDE_SPAN] != '0);
        div_dividend = r_wg;
        div_divisor  = cfg_reg[ebga_pkg::REG_WIDE_SPAN];
      end
      ebga_pkg::JOB_WIDE_X_MOD, ebga_pkg::JOB_WIDE_Y_MOD: begin
        need         = wfire;
        div_dividend = (cmd.job == ebga_pkg::JOB_WIDE_X_MOD) ? r_wx : r_wy;
        div_divisor  = ebga_pkg::WIDE_RANGE;
      end
      ebga_pkg::JOB_WIDE_X_TGT, ebga_pkg::JOB_WIDE_Y_TGT: begin
        need         = wfire;
        div_dividend = {2'd0, tmp, 14'd0} + ebga_pkg::WIDE_TGT_OFS;
        div_divisor  = ebga_pkg::TGT_DIV;
      end
      ebga_pkg::JOB_NAR_WAIT: begin
        need         = nfire && (cfg_reg[ebga_pkg::REG_NARROW_SPAN] != '0);
        div_dividend = r_ng;
        div_divisor  = cfg_reg[ebga_pkg::REG_NARROW_SPAN];
      end
      ebga_pkg::JOB_NAR_X_MOD, ebga_pkg::JOB_NAR_Y_MOD: begin
        need         = nfire;
        div_dividend = (cmd.job == ebga_pkg::JOB_NAR_X_MOD) ? r_nx : r_ny;
        div_divisor  = ebga_pkg::NARROW_RANGE;
      end
      ebga_pkg::JOB_NAR_X_TGT, ebga_pkg::JOB_NAR_Y_TGT: begin
        need         = nfire;
        div_dividend = {2'd0, tmp, 14'd0} + ebga_pkg::NARROW_TGT_OFS;
        div_divisor  = ebga_pkg::TGT_DIV;
      end
      ebga_pkg::JOB_SMOOTH_X, ebga_pkg::JOB_SMOOTH_Y: begin
        need         = 1'b1;
        div_dividend = {{15{wd[16]}}, wd} + ebga_pkg::SMOOTH_OFS;
        div_divisor  = ebga_pkg::SMOOTH_DIV;
      end
      default: begin
      end
    endcase
  end

  assign stat.need     = need;
  assign stat.div_done = div_done;
  assign stat.div_busy = div_busy;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[ebga_pkg::REG_BLINK_LEN]   <= ebga_pkg::RST_BLINK_LEN;
      cfg_reg[ebga_pkg::REG_BLINK_BASE]  <= ebga_pkg::RST_BLINK_BASE;
      cfg_reg[ebga_pkg::REG_BLINK_SPAN]  <= ebga_pkg::RST_BLINK_SPAN;
      cfg_reg[ebga_pkg::REG_WIDE_BASE]   <= ebga_pkg::RST_WIDE_BASE;
      cfg_reg[ebga_pkg::REG_WIDE_SPAN]   <= ebga_pkg::RST_WIDE_SPAN;
      cfg_reg[ebga_pkg::REG_NARROW_BASE] <= ebga_pkg::RST_NARROW_BASE;
      cfg_reg[ebga_pkg::REG_NARROW_SPAN] <= ebga_pkg::RST_NARROW_SPAN;
    end else if (cfg_we && (cfg_index < 3'(ebga_pkg::CFG_NUM))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // tick word and results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now  <= now_ms;
      ol   <= open_left_in;
      orr  <= open_right_in;
      gx   <= gaze_x_in;
      gy   <= gaze_y_in;
      r_bg <= rand_blink_gap;
      r_wg <= rand_wide_gap;
      r_wx <= rand_wide_x;
      r_wy <= rand_wide_y;
      r_ng <= rand_narrow_gap;
      r_nx <= rand_narrow_x;
      r_ny <= rand_narrow_y;
    end else if (cmd.apply && scale && (cmd.job == ebga_pkg::JOB_MUL_L)) begin
      ol <= prod[30:15];
    end else if (cmd.apply && scale && (cmd.job == ebga_pkg::JOB_MUL_R)) begin
      orr <= prod[30:15];
    end
    if (cmd.load_out) begin
      open_left_out  <= ol;
      open_right_out <= orr;
      gaze_x_out     <= sat16(sum_x);
      gaze_y_out     <= sat16(sum_y);
    end
    if (cmd.apply && (cmd.job == ebga_pkg::JOB_BLINK_F)) begin
      f <= quot[15:0];
    end
    if (cmd.apply && (cmd.job == ebga_pkg::JOB_WIDE_X_MOD || cmd.job == ebga_pkg::JOB_WIDE_Y_MOD
        || cmd.job == ebga_pkg::JOB_NAR_X_MOD || cmd.job == ebga_pkg::JOB_NAR_Y_MOD)) begin
      tmp <= rem;
    end
  end

  // timers, targets and offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      bstart   <= '0;
      bwait    <= '0;
      blinking <= 1'b0;
      wtime    <= '0;
      wwait    <= '0;
      ntime    <= '0;
      nwait    <= '0;
      bfire    <= 1'b0;
      wfire    <= 1'b0;
      nfire    <= 1'b0;
      scale    <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        wtgt[i] <= '0;
        ntgt[i] <= '0;
        wsm[i]  <= '0;
        nsm[i]  <= '0;
      end
    end else if (cmd.apply) begin
      case (cmd.job)
        ebga_pkg::JOB_BLINK_CHK: begin
          bfire <= !blinking && (el_b > {15'd0, bwait});
          if (!blinking && (el_b > {15'd0, bwait})) begin
            blinking <= 1'b1;
            bstart   <= now;
          end
        end
        ebga_pkg::JOB_BLINK_WAIT: begin
          if (bfire) begin
            bwait <= wait_sum(cfg_reg[ebga_pkg::REG_BLINK_BASE],
                              cfg_reg[ebga_pkg::REG_BLINK_SPAN], rem);
          end
        end
        ebga_pkg::JOB_BLINK_F: begin
          scale <= blinking && e_lt_len;
          if (blinking && !e_lt_len) begin
            blinking <= 1'b0;
          end
        end
        ebga_pkg::JOB_WIDE_CHK: begin
          wfire <= el_w > {15'd0, wwait};
          if (el_w > {15'd0, wwait}) begin
            wtime <= now;
          end
        end
        ebga_pkg::JOB_WIDE_WAIT: begin
          if (wfire) begin
            wwait <= wait_sum(cfg_reg[ebga_pkg::REG_WIDE_BASE],
                              cfg_reg[ebga_pkg::REG_WIDE_SPAN], rem);
          end
        end
        ebga_pkg::JOB_WIDE_X_TGT: begin
          if (wfire) wtgt[0] <= quot[15:0] - ebga_pkg::TGT_BIAS;
        end
        ebga_pkg::JOB_WIDE_Y_TGT: begin
          if (wfire) wtgt[1] <= quot[15:0] - ebga_pkg::TGT_BIAS;
        end
        ebga_pkg::JOB_NAR_CHK: begin
          nfire <= el_n > {15'd0, nwait};
          if (el_n > {15'd0, nwait}) begin
            ntime <= now;
          end
        end
        ebga_pkg::JOB_NAR_WAIT: begin
          if (nfire) begin
            nwait <= wait_sum(cfg_reg[ebga_pkg::REG_NARROW_BASE],
                              cfg_reg[ebga_pkg::REG_NARROW_SPAN], rem);
          end
        end
        ebga_pkg::JOB_NAR_X_TGT: begin
          if (nfire) ntgt[0] <= quot[15:0] - ebga_pkg::TGT_BIAS;
        end
        ebga_pkg::JOB_NAR_Y_TGT: begin
          if (nfire) ntgt[1] <= quot[15:0] - ebga_pkg::TGT_BIAS;
        end
        ebga_pkg::JOB_SMOOTH_X, ebga_pkg::JOB_SMOOTH_Y: begin
          // wide step is round(d/10), narrow step is round(d/2)
          wsm[sel] <= wsm[sel] + (quot[15:0] - ebga_pkg::SMOOTH_BIAS);
          nsm[sel] <= nsm[sel] + nd1[16:1];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/eye_blink_and_gaze_animator.sv
// ----------------------------------------------------------------------------
// eye_blink_and_gaze_animator
// Per-tick blink scaling of eye openness and random wide/narrow gaze offsets.
// ----------------------------------------------------------------------------
// One tick word in, one result word out. Every tick runs the two offset
// smoothing divisions; further divisions are added one while a blink runs,
// one more when a blink starts, and five for each gaze timer that fires.
// All divisions of a tick run in turn through the single shared divider,
// which retires four quotient bits per cycle. A new tick word is taken
// while the previous result still waits at the output.
module eye_blink_and_gaze_animator (
  input  logic       clk,
  input  logic       rst,
  ebga_in_if.sink    item,
  ebga_out_if.source result,
  ebga_cfg_if.sink   cfg
);

  ebga_pkg::ebga_cmd_t  cmd;
  ebga_pkg::ebga_stat_t stat;

  assign cfg.ready = 1'b1;

  ebga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ebga_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.reg_index),
    .cfg_data        (cfg.data),
    .now_ms          (item.now_ms),
    .open_left_in    (item.open_left_in),
    .open_right_in   (item.open_right_in),
    .gaze_x_in       (item.gaze_x_in),
    .gaze_y_in       (item.gaze_y_in),
    .rand_blink_gap  (item.rand_blink_gap),
    .rand_wide_gap   (item.rand_wide_gap),
    .rand_wide_x     (item.rand_wide_x),
    .rand_wide_y     (item.rand_wide_y),
    .rand_narrow_gap (item.rand_narrow_gap),
    .rand_narrow_x   (item.rand_narrow_x),
    .rand_narrow_y   (item.rand_narrow_y),
    .open_left_out   (result.open_left_out),
    .open_right_out  (result.open_right_out),
    .gaze_x_out      (result.gaze_x_out),
    .gaze_y_out      (result.gaze_y_out)
  );

`ifndef SYNTHESIS
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !stat.div_busy) else $error("divider restarted while busy");

  a_no_take_while_div: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !stat.div_busy) else $error("tick word taken mid division");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result word overwritten before taken");
`endif

endmodule
